// ===== sv/csc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int COORD_WIDTH   = 32;
	localparam int SAT_W         = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;

	// CORDIC datapath widths: x/y carry the gain on a 2^33 vector, z is Q5.28
	localparam int XW = 38;
	localparam int ZW = 34;

	localparam logic signed [ZW-1:0] PI_Q28      = 34'sd843314857;
	localparam logic signed [ZW-1:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [ZW-1:0] TWO_PI_Q28  = 34'sd1686629714;
	localparam logic signed [XW-1:0] K_Q30       = 38'sd652032874;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] sin_v;
		logic signed [31:0] cos_v;
	} lane_out_t;

	// atan(2^-i) in Q5.28, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q28(input int idx);
		logic signed [ZW-1:0] r;
		begin
			case (idx)
				0: r = 34'sd210828714;
				1: r = 34'sd124459457;
				2: r = 34'sd65760959;
				3: r = 34'sd33381290;
				4: r = 34'sd16755422;
				5: r = 34'sd8385879;
				6: r = 34'sd4193963;
				7: r = 34'sd2097109;
				8: r = 34'sd1048571;
				9: r = 34'sd524287;
				default: begin
					if (idx < 29)
						r = 34'sd1 <<< (28 - idx);
					else if (idx == 29)
						r = 34'sd1;
					else
						r = 34'sd0;
				end
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/csc_cordic_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_cordic_lane
// Pipelined CORDIC lane: atan2 by vectoring or sin/cos by rotation, per item.
// ----------------------------------------------------------------------------
module csc_cordic_lane
	import csc_pkg::*;
(
	input  logic                 clk,
	input  logic                 ce,
	input  logic                 vec,
	input  logic signed [33:0]   x_in,
	input  logic signed [33:0]   y_in,
	input  logic signed [31:0]   ang_in,
	output lane_out_t            res
);

	typedef struct packed {
		logic vec;
		logic zero;
		logic zneg;
		logic base_en;
		logic base_neg;
		logic flip;
	} side_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic        [32:0] m;
	} nrm_t;

	function automatic nrm_t norm_step(input nrm_t v, input int k);
		nrm_t r;
		begin
			r = v;
			if ((v.m >> (33 - k)) == 33'd0) begin
				r.x = v.x <<< k;
				r.y = v.y <<< k;
				r.m = v.m << k;
			end
			return r;
		end
	endfunction

	// prep
	logic signed [33:0] x_s1, y_s1, a_s1;
	logic        [32:0] m_s1;
	side_t              side_s1;

	logic               xneg;
	logic signed [33:0] ax, ay, ay_abs, a_ext, a_red;
	side_t              side_d1;

	always_comb begin
		xneg   = x_in[33];
		ax     = xneg ? -x_in : x_in;
		ay     = xneg ? -y_in : y_in;
		ay_abs = ay[33] ? -ay : ay;
		a_ext  = {{2{ang_in[31]}}, ang_in};
		if (a_ext > PI_Q28)
			a_red = a_ext - TWO_PI_Q28;
		else if (a_ext < -PI_Q28)
			a_red = a_ext + TWO_PI_Q28;
		else
			a_red = a_ext;
		side_d1.vec      = vec;
		side_d1.zero     = (y_in == 34'sd0);
		side_d1.zneg     = xneg;
		side_d1.base_en  = xneg;
		side_d1.base_neg = y_in[33];
		side_d1.flip     = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s1    <= ax;
			y_s1    <= ay;
			m_s1    <= (ax > ay_abs) ? ax[32:0] : ay_abs[32:0];
			a_s1    <= a_red;
			side_s1 <= side_d1;
		end
	end

	// coarse normalise / quadrant fold
	nrm_t               n_s2;
	logic signed [33:0] a_s2;
	side_t              side_s2;

	nrm_t               n_d2;
	logic signed [33:0] a_d2;
	logic               flip_d2;
	side_t              side_d2;

	always_comb begin
		n_d2 = norm_step(norm_step(norm_step('{x_s1, y_s1, m_s1}, 16), 8), 4);
		flip_d2 = 1'b0;
		a_d2    = a_s1;
		if (a_s1 > HALF_PI_Q28) begin
			a_d2    = a_s1 - PI_Q28;
			flip_d2 = 1'b1;
		end else if (a_s1 < -HALF_PI_Q28) begin
			a_d2    = a_s1 + PI_Q28;
			flip_d2 = 1'b1;
		end
		side_d2      = side_s1;
		side_d2.flip = flip_d2 & ~side_s1.vec;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			n_s2    <= n_d2;
			a_s2    <= a_d2;
			side_s2 <= side_d2;
		end
	end

	// fine normalise and CORDIC load
	logic signed [XW-1:0] cx_s3 [0:CORDIC_STAGES];
	logic signed [XW-1:0] cy_s3 [0:CORDIC_STAGES];
	logic signed [ZW-1:0] cz_s3 [0:CORDIC_STAGES];
	side_t                side_s3 [0:CORDIC_STAGES];

	nrm_t n_d3;

	always_comb begin
		n_d3 = norm_step(norm_step(norm_step(n_s2, 2), 1), 1);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (side_s2.vec) begin
				cx_s3[0] <= {{(XW-34){n_d3.x[33]}}, n_d3.x};
				cy_s3[0] <= {{(XW-34){n_d3.y[33]}}, n_d3.y};
				cz_s3[0] <= '0;
			end else begin
				cx_s3[0] <= K_Q30;
				cy_s3[0] <= '0;
				cz_s3[0] <= a_s2;
			end
			side_s3[0] <= side_s2;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		logic                 up;
		logic signed [XW-1:0] dx, dy;

		always_comb begin
			up = side_s3[i].vec ? cy_s3[i][XW-1] : ~cz_s3[i][ZW-1];
			dx = cy_s3[i] >>> i;
			dy = cx_s3[i] >>> i;
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				if (up) begin
					cx_s3[i+1] <= cx_s3[i] - dx;
					cy_s3[i+1] <= cy_s3[i] + dy;
					cz_s3[i+1] <= cz_s3[i] - atan_q28(i);
				end else begin
					cx_s3[i+1] <= cx_s3[i] + dx;
					cy_s3[i+1] <= cy_s3[i] - dy;
					cz_s3[i+1] <= cz_s3[i] + atan_q28(i);
				end
				side_s3[i+1] <= side_s3[i];
			end
		end
	end

	// post
	localparam logic signed [ZW:0] PI_W = {1'b0, PI_Q28};

	side_t              sd;
	logic signed [ZW:0] base, sum, ang_c;
	logic signed [XW-1:0] xf, yf;
	lane_out_t          res_d4;

	always_comb begin
		sd   = side_s3[CORDIC_STAGES];
		base = sd.base_en ? (sd.base_neg ? -PI_W : PI_W) : '0;
		sum  = {cz_s3[CORDIC_STAGES][ZW-1], cz_s3[CORDIC_STAGES]} + base;
		if (sd.zero)
			ang_c = sd.zneg ? PI_W : '0;
		else if (sum > PI_W)
			ang_c = PI_W;
		else if (sum < -PI_W)
			ang_c = -PI_W;
		else
			ang_c = sum;
		xf = sd.flip ? -cx_s3[CORDIC_STAGES] : cx_s3[CORDIC_STAGES];
		yf = sd.flip ? -cy_s3[CORDIC_STAGES] : cy_s3[CORDIC_STAGES];
		res_d4.angle = ang_c[31:0];
		res_d4.cos_v = xf[31:0];
		res_d4.sin_v = yf[31:0];
	end

	lane_out_t res_s4;

	always_ff @(posedge clk) begin
		if (ce)
			res_s4 <= res_d4;
	end

	assign res = res_s4;

endmodule

// ===== sv/cartesian_spherical_converter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_spherical_converter_core
// Cartesian <-> spherical conversion of one three-component vector per item.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata carries comp_first, comp_second, comp_third
// (32 bits each, lowest first); tuser[0] is mode (0: x,y,z -> r,theta,phi;
// 1: r,theta,phi -> x,y,z). Output stream m_axis: tdata carries res_first,
// res_second, res_third; tuser[0] is the saturated flag.
// Coordinates are Q16.16, angles Q3.28 radians.
// Path from input acceptance to m_axis tvalid: the squares and their sums,
// 32 square-root stages plus rounding, the two parallel CORDIC lanes, then
// the products and saturation.
// Throughput: one item per cycle while the output is taken.
// A two-entry output buffer sits behind the pipeline; the pipeline halts
// only when both entries are full, so tready stays high while one finished
// item waits. Nothing is dropped or repeated on a stall.
// Reset clears all valid bits and the output buffer; no items are in flight
// afterwards.
// ----------------------------------------------------------------------------
module cartesian_spherical_converter_core
	import csc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // comp_first, comp_second, comp_third
	input  logic [0:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // res_first, res_second, res_third
	output logic [0:0]  m_axis_tuser   // saturated
);

	localparam int SQ_STAGES = 32;
	localparam int LANE_LAT  = CORDIC_STAGES + 4;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	function automatic sq_t sqrt_step(input sq_t in, input int j);
		logic [63:0] bitv, t;
		sq_t         o;
		begin
			bitv = 64'd1 << (62 - 2 * j);
			t    = in.r + bitv;
			if (in.v >= t) begin
				o.v = in.v - t;
				o.r = (in.r >> 1) + bitv;
			end else begin
				o.v = in.v;
				o.r = in.r >> 1;
			end
			return o;
		end
	endfunction

	localparam logic signed [35:0] SAT_HI = COORD_MAX[35:0];
	localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

	logic ce;

	// ---- stage 1: squares
	logic               valid_s1, mode_s1;
	logic signed [31:0] a_s1, b_s1, c_s1;
	logic signed [63:0] aa_s1, bb_s1, cc_s1;
	logic signed [31:0] a_in, b_in, c_in;

	assign a_in = s_axis_tdata[31:0];
	assign b_in = s_axis_tdata[63:32];
	assign c_in = s_axis_tdata[95:64];

	always_ff @(posedge clk) begin
		if (ce) begin
			mode_s1 <= s_axis_tuser[0];
			a_s1    <= a_in;
			b_s1    <= b_in;
			c_s1    <= c_in;
			aa_s1   <= a_in * a_in;
			bb_s1   <= b_in * b_in;
			cc_s1   <= c_in * c_in;
		end
	end

	// ---- stage 2: sums of squares
	logic               valid_s2, mode_s2;
	logic signed [31:0] a_s2, b_s2, c_s2;
	logic        [63:0] sxy_s2, rad2_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			mode_s2 <= mode_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;
			sxy_s2  <= aa_s1 + bb_s1;
			rad2_s2 <= aa_s1 + bb_s1 + cc_s1;
		end
	end

	// ---- stage 3: square roots, one result bit per stage
	sq_t                sxy_s3  [0:SQ_STAGES-1];
	sq_t                rad_s3  [0:SQ_STAGES-1];
	logic               valid_s3[0:SQ_STAGES-1];
	logic               mode_s3 [0:SQ_STAGES-1];
	logic signed [31:0] a_s3    [0:SQ_STAGES-1];
	logic signed [31:0] b_s3    [0:SQ_STAGES-1];
	logic signed [31:0] c_s3    [0:SQ_STAGES-1];

	always_ff @(posedge clk) begin
		if (ce) begin
			sxy_s3[0]  <= sqrt_step('{sxy_s2, 64'd0}, 0);
			rad_s3[0]  <= sqrt_step('{rad2_s2, 64'd0}, 0);
			mode_s3[0] <= mode_s2;
			a_s3[0]    <= a_s2;
			b_s3[0]    <= b_s2;
			c_s3[0]    <= c_s2;
		end
	end

	for (genvar j = 1; j < SQ_STAGES; j++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (ce) begin
				sxy_s3[j]  <= sqrt_step(sxy_s3[j-1], j);
				rad_s3[j]  <= sqrt_step(rad_s3[j-1], j);
				mode_s3[j] <= mode_s3[j-1];
				a_s3[j]    <= a_s3[j-1];
				b_s3[j]    <= b_s3[j-1];
				c_s3[j]    <= c_s3[j-1];
			end
		end
	end

	// ---- stage 4: round to nearest
	logic               valid_s4, mode_s4;
	logic signed [31:0] a_s4, b_s4, c_s4;
	logic        [32:0] rho_s4, rad_s4;
	sq_t                sxy_l, rad_l;

	assign sxy_l = sxy_s3[SQ_STAGES-1];
	assign rad_l = rad_s3[SQ_STAGES-1];

	always_ff @(posedge clk) begin
		if (ce) begin
			mode_s4 <= mode_s3[SQ_STAGES-1];
			a_s4    <= a_s3[SQ_STAGES-1];
			b_s4    <= b_s3[SQ_STAGES-1];
			c_s4    <= c_s3[SQ_STAGES-1];
			rho_s4  <= sxy_l.r[32:0] + {32'd0, (sxy_l.v > sxy_l.r)};
			rad_s4  <= rad_l.r[32:0] + {32'd0, (rad_l.v > rad_l.r)};
		end
	end

	// ---- stage 5: CORDIC lanes (A: phi or theta sin/cos, B: theta or phi sin/cos)
	lane_out_t lane_a, lane_b;

	csc_cordic_lane u_lane_a (
		.clk    (clk),
		.ce     (ce),
		.vec    (~mode_s4),
		.x_in   ({{2{a_s4[31]}}, a_s4}),
		.y_in   ({{2{b_s4[31]}}, b_s4}),
		.ang_in (b_s4),
		.res    (lane_a)
	);

	csc_cordic_lane u_lane_b (
		.clk    (clk),
		.ce     (ce),
		.vec    (~mode_s4),
		.x_in   ({{2{c_s4[31]}}, c_s4}),
		.y_in   ({1'b0, rho_s4}),
		.ang_in (c_s4),
		.res    (lane_b)
	);

	logic               valid_s5[0:LANE_LAT-1];
	logic               mode_s5 [0:LANE_LAT-1];
	logic signed [31:0] a_s5    [0:LANE_LAT-1];
	logic signed [31:0] r1_s5   [0:LANE_LAT-1];
	logic               sat_s5  [0:LANE_LAT-1];
	logic               rad_over;

	assign rad_over = 64'(rad_s4) > COORD_MAX;

	always_ff @(posedge clk) begin
		if (ce) begin
			mode_s5[0] <= mode_s4;
			a_s5[0]    <= a_s4;
			r1_s5[0]   <= rad_over ? COORD_MAX[31:0] : rad_s4[31:0];
			sat_s5[0]  <= rad_over;
		end
	end

	for (genvar k = 1; k < LANE_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (ce) begin
				mode_s5[k] <= mode_s5[k-1];
				a_s5[k]    <= a_s5[k-1];
				r1_s5[k]   <= r1_s5[k-1];
				sat_s5[k]  <= sat_s5[k-1];
			end
		end
	end

	// ---- stage 6: r*sin(theta), r*cos(theta)
	logic               valid_s6, mode_s6, sat_s6;
	logic signed [33:0] rs_s6, zc_s6;
	logic signed [31:0] sp_s6, cp_s6, r1_s6, th_s6, ph_s6;
	logic signed [63:0] prod_rs, prod_zc;

	always_comb begin
		prod_rs = a_s5[LANE_LAT-1] * lane_a.sin_v + (64'sd1 <<< 29);
		prod_zc = a_s5[LANE_LAT-1] * lane_a.cos_v + (64'sd1 <<< 29);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mode_s6 <= mode_s5[LANE_LAT-1];
			sat_s6  <= sat_s5[LANE_LAT-1];
			r1_s6   <= r1_s5[LANE_LAT-1];
			rs_s6   <= prod_rs[63:30];
			zc_s6   <= prod_zc[63:30];
			sp_s6   <= lane_b.sin_v;
			cp_s6   <= lane_b.cos_v;
			th_s6   <= lane_b.angle[31] ? 32'sd0 : lane_b.angle;
			ph_s6   <= lane_a.angle;
		end
	end

	// ---- stage 7: times cos(phi), sin(phi)
	logic               valid_s7, mode_s7, sat_s7;
	logic signed [35:0] px_s7, py_s7;
	logic signed [33:0] zc_s7;
	logic signed [31:0] r1_s7, th_s7, ph_s7;
	logic signed [65:0] prod_x, prod_y;

	always_comb begin
		prod_x = rs_s6 * cp_s6 + (66'sd1 <<< 29);
		prod_y = rs_s6 * sp_s6 + (66'sd1 <<< 29);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mode_s7 <= mode_s6;
			sat_s7  <= sat_s6;
			r1_s7   <= r1_s6;
			th_s7   <= th_s6;
			ph_s7   <= ph_s6;
			zc_s7   <= zc_s6;
			px_s7   <= prod_x[65:30];
			py_s7   <= prod_y[65:30];
		end
	end

	// ---- stage 8: saturation and result select
	logic               valid_s8, sat_s8;
	logic signed [31:0] f1_s8, f2_s8, f3_s8;
	logic signed [35:0] zc_w;
	logic               ox, oy, oz;

	always_comb begin
		zc_w = {{2{zc_s7[33]}}, zc_s7};
		ox   = (px_s7 > SAT_HI) || (px_s7 < SAT_LO);
		oy   = (py_s7 > SAT_HI) || (py_s7 < SAT_LO);
		oz   = (zc_w > SAT_HI) || (zc_w < SAT_LO);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (mode_s7) begin
				f1_s8  <= ox ? (px_s7[35] ? SAT_LO[31:0] : SAT_HI[31:0]) : px_s7[31:0];
				f2_s8  <= oy ? (py_s7[35] ? SAT_LO[31:0] : SAT_HI[31:0]) : py_s7[31:0];
				f3_s8  <= oz ? (zc_w[35] ? SAT_LO[31:0] : SAT_HI[31:0]) : zc_w[31:0];
				sat_s8 <= ox | oy | oz;
			end else begin
				f1_s8  <= r1_s7;
				f2_s8  <= th_s7;
				f3_s8  <= ph_s7;
				sat_s8 <= sat_s7;
			end
		end
	end

	// ---- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s4 <= valid_s3[SQ_STAGES-1];
			valid_s6 <= valid_s5[LANE_LAT-1];
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_vsq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s3[j] <= 1'b0;
			else if (ce)
				valid_s3[j] <= (j == 0) ? valid_s2 : valid_s3[(j == 0) ? 0 : j-1];
		end
	end

	for (genvar k = 0; k < LANE_LAT; k++) begin : g_vln
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s5[k] <= 1'b0;
			else if (ce)
				valid_s5[k] <= (k == 0) ? valid_s4 : valid_s5[(k == 0) ? 0 : k-1];
		end
	end

	// ---- two-entry output buffer
	logic        head_valid_q, skid_valid_q;
	logic [96:0] head_q, skid_q;
	logic [96:0] new_item;
	logic        push, pop;

	assign ce       = ~skid_valid_q;
	assign push     = ce & valid_s8;
	assign pop      = head_valid_q & m_axis_tready;
	assign new_item = {sat_s8, f3_s8, f2_s8, f1_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					head_valid_q <= push;
				end
			end else if (push) begin
				if (head_valid_q)
					skid_valid_q <= 1'b1;
				else
					head_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				head_q <= skid_q;
			else if (push)
				head_q <= new_item;
		end else if (push) begin
			if (head_valid_q)
				skid_q <= new_item;
			else
				head_q <= new_item;
		end
	end

	assign s_axis_tready = ce;
	assign m_axis_tvalid = head_valid_q;
	assign m_axis_tdata  = head_q[95:0];
	assign m_axis_tuser  = head_q[96:96];

endmodule

// ===== sv/csc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the coordinate converter, bound to the top level.
// ----------------------------------------------------------------------------
module csc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// back-pressure only when a result is waiting at the output
	a_ready_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no item at the output");

	// taking an item always frees room for the next input
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
		else $error("input still stalled after an item was taken");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output item withdrawn");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output item changed");

endmodule

bind cartesian_spherical_converter_core csc_checker u_csc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the Cartesian/spherical converter: directed corner
// vectors, then random vectors in both modes under several idle/stall mixes,
// each result compared field by field with a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
module testbench;
	import csc_pkg::*;

	typedef struct packed {
		logic signed [31:0] first;
		logic signed [31:0] second;
		logic signed [31:0] third;
		logic               sat;
	} vec_result_t;

	class conversion_scoreboard;
		longint      atan_tab[CORDIC_STAGES];
		longint      pi_q, half_pi_q;
		vec_result_t pending[$];
		bit          failed;

		function new();
			longint unsigned quarter, v;
			quarter = atan_recip(2) + atan_recip(3);
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				if (i == 0)
					v = quarter;
				else if (i <= 20)
					v = atan_recip(64'd1 << i);
				else
					v = (64'd1 << 62) >> i;
				atan_tab[i] = longint'((v + (64'd1 << 33)) >> 34);
			end
			pi_q      = longint'((quarter * 4 + (64'd1 << 33)) >> 34);
			half_pi_q = longint'((quarter * 2 + (64'd1 << 33)) >> 34);
			failed    = 0;
		endfunction

		// atan(1/n) in Q62, alternating series
		function longint unsigned atan_recip(longint unsigned n);
			longint unsigned n2, p, sum, k;
			bit sub;
			n2  = n * n;
			p   = (64'd1 << 62) / n;
			sum = p;
			k   = 1;
			sub = 1;
			forever begin
				p = p / n2;
				if (p == 0)
					break;
				if (sub)
					sum -= p / (2 * k + 1);
				else
					sum += p / (2 * k + 1);
				sub = !sub;
				k++;
			end
			return sum;
		endfunction

		function longint unsigned root_rounded(longint unsigned s);
			longint unsigned v, res, bitv;
			v    = s;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v  -= res + bitv;
					res = (res >> 1) + bitv;
				end else
					res >>= 1;
				bitv >>= 2;
			end
			if (s - res * res > res)
				res++;
			return res;
		endfunction

		function longint clamp(longint a, longint lo, longint hi);
			return a < lo ? lo : (a > hi ? hi : a);
		endfunction

		function longint vector_angle(longint y, longint x);
			longint base, z, ay, dx, dy;
			longint unsigned m;
			base = 0;
			z    = 0;
			if (y == 0)
				return x >= 0 ? 0 : pi_q;
			if (x < 0) begin
				base = y > 0 ? pi_q : -pi_q;
				x = -x;
				y = -y;
			end
			ay = y < 0 ? -y : y;
			m  = x > ay ? x : ay;
			while (m < (64'd1 << 32)) begin
				x *= 2;
				y *= 2;
				m *= 2;
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y < 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			return clamp(base + z, -pi_q, pi_q);
		endfunction

		function void rotate_unit(longint a, output longint s, output longint c);
			longint x, y, dx, dy;
			bit flip;
			x    = longint'(K_Q30);
			y    = 0;
			flip = 0;
			while (a > pi_q)
				a -= 2 * pi_q;
			while (a < -pi_q)
				a += 2 * pi_q;
			if (a > half_pi_q) begin
				a -= pi_q; flip = 1;
			end else if (a < -half_pi_q) begin
				a += pi_q; flip = 1;
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (a >= 0) begin
					x -= dx; y += dy; a -= atan_tab[i];
				end else begin
					x += dx; y -= dy; a += atan_tab[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint mul_round(longint a, longint b);
			return (a * b + (64'sd1 <<< 29)) >>> 30;
		endfunction

		function longint clip(longint v, inout logic sat);
			if (v > COORD_MAX) begin
				sat = 1;
				return COORD_MAX;
			end
			if (v < -COORD_MAX - 1) begin
				sat = 1;
				return -COORD_MAX - 1;
			end
			return v;
		endfunction

		function void note_input(logic mode, logic signed [31:0] p, logic signed [31:0] q,
				logic signed [31:0] w);
			longint a, b, c, st, ct, sp, cp, rs;
			longint unsigned sxy, rho, rad;
			vec_result_t e;
			a = p;
			b = q;
			c = w;
			e.sat = 0;
			if (!mode) begin
				sxy = longint'(a * a) + longint'(b * b);
				rho = root_rounded(sxy);
				rad = root_rounded(sxy + longint'(c * c));
				if (rad > COORD_MAX) begin
					e.sat   = 1;
					e.first = 32'(COORD_MAX);
				end else
					e.first = 32'(rad);
				e.second = 32'(clamp(vector_angle(longint'(rho), c), 0, pi_q));
				e.third  = 32'(vector_angle(b, a));
			end else begin
				rotate_unit(b, st, ct);
				rotate_unit(c, sp, cp);
				rs       = mul_round(a, st);
				e.first  = 32'(clip(mul_round(rs, cp), e.sat));
				e.second = 32'(clip(mul_round(rs, sp), e.sat));
				e.third  = 32'(clip(mul_round(a, ct), e.sat));
			end
			pending.push_back(e);
		endfunction

		function void check_result(logic [95:0] data, logic sat);
			vec_result_t e, got;
			got = {data[31:0], data[63:32], data[95:64], sat};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h sat %b", $time, data, sat);
				failed = 1;
				return;
			end
			e = pending.pop_front();
			if (got.first !== e.first) begin
				$display("%0t: res_first exp %0d got %0d", $time, e.first, got.first);
				failed = 1;
			end
			if (got.second !== e.second) begin
				$display("%0t: res_second exp %0d got %0d", $time, e.second, got.second);
				failed = 1;
			end
			if (got.third !== e.third) begin
				$display("%0t: res_third exp %0d got %0d", $time, e.third, got.third);
				failed = 1;
			end
			if (got.sat !== e.sat) begin
				$display("%0t: saturated exp %b got %b", $time, e.sat, got.sat);
				failed = 1;
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	conversion_scoreboard sb = new();
	int  gap_pct, stall_pct, quiet_cycles;
	bit  hold_off;

	cartesian_spherical_converter_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_input(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32],
				s_axis_tdata[95:64]);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_vec(logic mode, logic [31:0] p, logic [31:0] q, logic [31:0] w);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tuser  = mode;
		s_axis_tdata  = {w, q, p};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2000)) - 1000;
			2: return 0;
			default: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		if ($urandom_range(2) == 0)
			return $urandom;
		return $signed($urandom_range(2 * 843314857)) - 843314857;
	endfunction

	task automatic random_phase(int n);
		repeat (n) begin
			if ($urandom_range(1))
				send_vec(1'b0, rand_coord(), rand_coord(), rand_coord());
			else
				send_vec(1'b1, rand_coord(), rand_angle(), rand_angle());
		end
	endtask

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		hold_off      = 0;
		gap_pct       = 0;
		stall_pct     = 0;
		arst_n        = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed corners: origin, axes, zero ordinate, radius overflow
		send_vec(0, 0, 0, 0);
		send_vec(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vec(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(0, -1, 0, 0);
		send_vec(0, 5, 0, -7);
		send_vec(0, 0, -5, 0);
		send_vec(0, 0, 0, -1);
		send_vec(0, 32'h8000_0000, 0, 0);
		send_vec(0, 1, 1, 1);
		send_vec(0, 32'h7FFF_FFFF, 0, 0);
		// rotation: zero radius, full angles, wrap, negative radius, overflow
		send_vec(1, 0, 843314857, 0);
		send_vec(1, 32'h7FFF_FFFF, 0, 0);
		send_vec(1, 32'h8000_0000, 0, 0);
		send_vec(1, 32'h7FFF_FFFF, 421657428, 0);
		send_vec(1, 32'h0001_0000, 843314857, -843314857);
		send_vec(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_vec(1, -32'sh0001_0000, 300000000, 600000000);
		send_vec(1, 32'h7FFF_FFFF, 210828714, 210828714);
		send_vec(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// long receiver hold while items keep coming
		hold_off = 1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			random_phase(200);
		join
		random_phase(200);
		gap_pct = 70; stall_pct = 0;  random_phase(380);
		gap_pct = 0;  stall_pct = 70; random_phase(380);
		gap_pct = 25; stall_pct = 25; random_phase(380);
		gap_pct = 0;  stall_pct = 0;  random_phase(390);
		s_axis_tvalid = 0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.failed)
			$display("Some tests failed");
		else
			$display("All tests passed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/csc_pkg.sv
sv/csc_cordic_lane.sv
sv/cartesian_spherical_converter_core.sv
sv/csc_checker.sv
tb/testbench.sv
